/* sv/ramc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramc_pkg
// Shared types and constants of the rover autonomy mode controller.
// ----------------------------------------------------------------------------
package ramc_pkg;

	// Controller timing, in ticks.
	localparam int MANUAL_HOLD_TICKS = 100;
	localparam int SEARCH_TICKS      = 300;
	localparam int RETURN_TICKS      = 50;
	localparam int LOST_TICKS        = 30;

	// Echo widths above this limit give no range.
	localparam int ECHO_LIMIT_US = 4000;

	// Counter widths follow from the bounds they can reach.
	localparam int RH_W = $clog2(RETURN_TICKS + 1);
	localparam int LH_W = $clog2(MANUAL_HOLD_TICKS + 1);
	localparam int SC_W = $clog2(SEARCH_TICKS + 1);
	localparam int LC_W = $clog2(LOST_TICKS + 2);

	// Field widths.
	localparam int US_W    = 14;
	localparam int MM_W    = 10;
	localparam int ECHO_W  = 16;
	localparam int MODE_W  = 2;

	// Range arithmetic: range = echo * 17 / 100, with the division done as a
	// multiply by a rounded-up reciprocal of 100 scaled by 2^RECIP_SHIFT.
	// The rounding error stays below one count for every 16-bit echo.
	localparam int RECIP_SHIFT = 28;
	localparam longint RECIP_100 = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
	localparam int SCALE_W = 26;
	localparam logic [SCALE_W-1:0] RANGE_SCALE = SCALE_W'(64'd17 * RECIP_100);
	localparam int PROD_W = ECHO_W + SCALE_W;
	localparam int QUOT_W = PROD_W - RECIP_SHIFT;

	// Range in millimetres above which a target counts as seen.
	localparam logic [MM_W-1:0] SEEN_MIN_MM    = MM_W'(5);
	localparam logic [MM_W:0]   TARGET_BACK_MM = (MM_W+1)'(25);
	localparam logic [MM_W:0]   TRACK_BAND_MM  = (MM_W+1)'(10);

	// Register indexes.
	typedef enum logic [2:0] {
		REG_LEFT_LIMIT   = 3'd0,
		REG_RIGHT_COARSE = 3'd1,
		REG_RIGHT_EXACT  = 3'd2,
		REG_STOP_A       = 3'd3,
		REG_STOP_B       = 3'd4,
		REG_FORWARD      = 3'd5,
		REG_BACKWARD     = 3'd6,
		REG_SAFE_RANGE   = 3'd7
	} reg_idx_t;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Reset values of the registers.
	localparam logic [US_W-1:0] LEFT_LIMIT_RST   = US_W'(1200);
	localparam logic [US_W-1:0] RIGHT_COARSE_RST = US_W'(1800);
	localparam logic [US_W-1:0] RIGHT_EXACT_RST  = US_W'(1575);
	localparam logic [US_W-1:0] STOP_A_RST       = US_W'(1500);
	localparam logic [US_W-1:0] STOP_B_RST       = US_W'(13500);
	localparam logic [US_W-1:0] FORWARD_RST      = US_W'(13350);
	localparam logic [US_W-1:0] BACKWARD_RST     = US_W'(13650);
	localparam logic [MM_W-1:0] SAFE_RANGE_RST   = MM_W'(150);

	typedef struct packed {
		logic [US_W-1:0] left_limit_us;
		logic [US_W-1:0] right_coarse_us;
		logic [US_W-1:0] right_exact_us;
		logic [US_W-1:0] stop_a_us;
		logic [US_W-1:0] stop_b_us;
		logic [US_W-1:0] forward_us;
		logic [US_W-1:0] backward_us;
		logic [MM_W-1:0] safe_range_mm;
	} ramc_cfg_t;

	typedef struct packed {
		logic [US_W-1:0]   pwm_a_in_us;
		logic [US_W-1:0]   pwm_b_in_us;
		logic [ECHO_W-1:0] echo_width_us;
		logic              infrared_seen;
	} ramc_in_t;

	typedef struct packed {
		logic [US_W-1:0]   drive_a_us;
		logic [US_W-1:0]   drive_b_us;
		logic [MODE_W-1:0] run_mode;
		logic [MM_W-1:0]   range_mm;
	} ramc_out_t;

	typedef struct packed {
		logic [MM_W-1:0] range_mm;
		logic            seen;
	} ramc_range_t;

	typedef enum logic [3:0] {
		MODE_MANUAL = 4'b0001,
		MODE_ROAM   = 4'b0010,
		MODE_SEARCH = 4'b0100,
		MODE_TRACK  = 4'b1000
	} mode_t;

	localparam logic [MODE_W-1:0] RUN_MANUAL = 2'd0;
	localparam logic [MODE_W-1:0] RUN_ROAM   = 2'd1;
	localparam logic [MODE_W-1:0] RUN_SEARCH = 2'd2;
	localparam logic [MODE_W-1:0] RUN_TRACK  = 2'd3;

	function automatic logic [MODE_W-1:0] run_code(mode_t m);
		logic [MODE_W-1:0] code;
		unique case (m)
			MODE_ROAM:   code = RUN_ROAM;
			MODE_SEARCH: code = RUN_SEARCH;
			MODE_TRACK:  code = RUN_TRACK;
			default:     code = RUN_MANUAL;
		endcase
		return code;
	endfunction

endpackage

/* sv/ramc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramc_regs
// APB-style register file holding the controller thresholds and drive widths.
// ----------------------------------------------------------------------------
module ramc_regs import ramc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output ramc_cfg_t          cfg
);

	ramc_cfg_t cfg_q;
	reg_idx_t  idx;
	logic      wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_limit_us   <= LEFT_LIMIT_RST;
			cfg_q.right_coarse_us <= RIGHT_COARSE_RST;
			cfg_q.right_exact_us  <= RIGHT_EXACT_RST;
			cfg_q.stop_a_us       <= STOP_A_RST;
			cfg_q.stop_b_us       <= STOP_B_RST;
			cfg_q.forward_us      <= FORWARD_RST;
			cfg_q.backward_us     <= BACKWARD_RST;
			cfg_q.safe_range_mm   <= SAFE_RANGE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_LEFT_LIMIT:   cfg_q.left_limit_us   <= pwdata[US_W-1:0];
				REG_RIGHT_COARSE: cfg_q.right_coarse_us <= pwdata[US_W-1:0];
				REG_RIGHT_EXACT:  cfg_q.right_exact_us  <= pwdata[US_W-1:0];
				REG_STOP_A:       cfg_q.stop_a_us       <= pwdata[US_W-1:0];
				REG_STOP_B:       cfg_q.stop_b_us       <= pwdata[US_W-1:0];
				REG_FORWARD:      cfg_q.forward_us      <= pwdata[US_W-1:0];
				REG_BACKWARD:     cfg_q.backward_us     <= pwdata[US_W-1:0];
				REG_SAFE_RANGE:   cfg_q.safe_range_mm   <= pwdata[MM_W-1:0];
				default:          cfg_q                 <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LEFT_LIMIT:   prdata = PDATA_W'(cfg_q.left_limit_us);
			REG_RIGHT_COARSE: prdata = PDATA_W'(cfg_q.right_coarse_us);
			REG_RIGHT_EXACT:  prdata = PDATA_W'(cfg_q.right_exact_us);
			REG_STOP_A:       prdata = PDATA_W'(cfg_q.stop_a_us);
			REG_STOP_B:       prdata = PDATA_W'(cfg_q.stop_b_us);
			REG_FORWARD:      prdata = PDATA_W'(cfg_q.forward_us);
			REG_BACKWARD:     prdata = PDATA_W'(cfg_q.backward_us);
			REG_SAFE_RANGE:   prdata = PDATA_W'(cfg_q.safe_range_mm);
			default:          prdata = '0;
		endcase
	end

endmodule

/* sv/ramc_range.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramc_range
// Converts an ultrasonic echo width into a range in millimetres.
// ----------------------------------------------------------------------------
module ramc_range import ramc_pkg::*; (
	input  logic [ECHO_W-1:0] echo_width_us,
	output ramc_range_t       rng
);

	logic [PROD_W-1:0] prod;
	logic [QUOT_W-1:0] quot;

	// One multiply by 17/100 in fixed point; the high bits are the floor.
	assign prod = PROD_W'(echo_width_us) * PROD_W'(RANGE_SCALE);
	assign quot = prod[PROD_W-1:RECIP_SHIFT];

	always_comb begin
		if (echo_width_us > ECHO_W'(ECHO_LIMIT_US)) begin
			rng.range_mm = '0;
		end else if (quot > QUOT_W'({MM_W{1'b1}})) begin
			rng.range_mm = {MM_W{1'b1}};
		end else begin
			rng.range_mm = quot[MM_W-1:0];
		end
		rng.seen = rng.range_mm > SEEN_MIN_MM;
	end

endmodule

/* sv/rover_autonomy_mode_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rover_autonomy_mode_controller_core
// Four-mode rover controller: manual pass-through, roam, search and track.
// ----------------------------------------------------------------------------
// A word accepted into the input register is loaded into the result register
// once that register is free, and is offered on the output from then on.
// Throughput: one word per cycle unless the output stalls; the input register
// and result register each hold one word; the mode logic is combinational.
// Reset: arst_n clears both registers' valid flags, returns the mode to manual,
// clears all hold, search and lost counters and the target range, and loads
// the register defaults.
module rover_autonomy_mode_controller_core import ramc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ramc_in_t           in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output ramc_out_t          out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	ramc_cfg_t   cfg;
	ramc_range_t rng;

	ramc_in_t  word_s1;
	logic      valid_s1;
	ramc_out_t out_word_q;
	logic      out_valid_q;
	logic      advance;

	mode_t           mode_q, mode_n;
	logic [RH_W-1:0] rh_q, rh_n;
	logic [LH_W-1:0] lh_q, lh_n;
	logic [SC_W-1:0] sc_q, sc_n;
	logic [LC_W-1:0] lc_q, lc_n;
	logic [MM_W-1:0] tg_q, tg_n;
	logic [US_W-1:0] da, db;
	logic [MM_W-1:0] new_tg;
	logic [MM_W:0]   rng_x, tg_x;

	ramc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ramc_range u_range (
		.echo_width_us (word_s1.echo_width_us),
		.rng           (rng)
	);

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	assign rng_x = (MM_W+1)'(rng.range_mm);
	assign tg_x  = (MM_W+1)'(tg_q);

	// A new target sits 25 mm short of the range, but never below the safe range.
	assign new_tg = (rng_x < (MM_W+1)'(cfg.safe_range_mm) + TARGET_BACK_MM)
		? cfg.safe_range_mm : MM_W'(rng_x - TARGET_BACK_MM);

	always_comb begin
		mode_n = mode_q;
		rh_n   = rh_q;
		lh_n   = lh_q;
		sc_n   = sc_q;
		lc_n   = lc_q;
		tg_n   = tg_q;

		// The right-stick hold is checked ahead of the mode logic.
		if (word_s1.pwm_a_in_us >= cfg.right_coarse_us) begin
			lh_n = '0;
			if (rh_q == RH_W'(RETURN_TICKS)) begin
				mode_n = MODE_MANUAL;
			end else begin
				rh_n = rh_q + RH_W'(1);
			end
		end else begin
			rh_n = '0;
		end

		da = cfg.stop_a_us;
		db = cfg.stop_b_us;
		unique case (mode_n)
			MODE_TRACK: begin
				if (rng.seen) begin
					if (rng_x > tg_x + TRACK_BAND_MM) begin
						db = cfg.forward_us;
					end else if (rng_x + TRACK_BAND_MM < tg_x) begin
						db = cfg.backward_us;
					end
				end else if (lc_q > LC_W'(LOST_TICKS)) begin
					mode_n = MODE_SEARCH;
					lc_n   = '0;
					sc_n   = '0;
					da     = cfg.right_exact_us;
				end else begin
					lc_n = lc_q + LC_W'(1);
				end
			end
			MODE_SEARCH: begin
				if (rng.seen) begin
					mode_n = MODE_TRACK;
					tg_n   = new_tg;
				end else if (sc_q >= SC_W'(SEARCH_TICKS)) begin
					mode_n = MODE_ROAM;
					da     = cfg.right_coarse_us;
				end else begin
					sc_n = sc_q + SC_W'(1);
					da   = cfg.right_exact_us;
				end
			end
			MODE_ROAM: begin
				if (word_s1.infrared_seen) begin
					if (rng.seen) begin
						mode_n = MODE_TRACK;
						tg_n   = new_tg;
					end else begin
						mode_n = MODE_SEARCH;
						sc_n   = '0;
						da     = cfg.right_exact_us;
					end
				end else begin
					da = cfg.right_coarse_us;
				end
			end
			default: begin
				da = word_s1.pwm_a_in_us;
				db = word_s1.pwm_b_in_us;
				if (word_s1.pwm_a_in_us <= cfg.left_limit_us) begin
					if (lh_n >= LH_W'(MANUAL_HOLD_TICKS)) begin
						mode_n = MODE_ROAM;
						lh_n   = '0;
						da     = cfg.right_coarse_us;
						db     = cfg.stop_b_us;
					end else begin
						lh_n = lh_n + LH_W'(1);
					end
				end else begin
					lh_n = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_MANUAL;
			rh_q        <= '0;
			lh_q        <= '0;
			sc_q        <= '0;
			lc_q        <= '0;
			tg_q        <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				mode_q      <= mode_n;
				rh_q        <= rh_n;
				lh_q        <= lh_n;
				sc_q        <= sc_n;
				lc_q        <= lc_n;
				tg_q        <= tg_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
		if (advance) begin
			out_word_q.drive_a_us <= da;
			out_word_q.drive_b_us <= db;
			out_word_q.run_mode   <= run_code(mode_n);
			out_word_q.range_mm   <= rng.range_mm;
		end
	end

	// The input side stalls only when both registers are full and the output is held.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while a register had room");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed word did not reach the output register");

	a_counters_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(rh_q <= RH_W'(RETURN_TICKS)) && (sc_q <= SC_W'(SEARCH_TICKS))
		&& (lc_q <= LC_W'(LOST_TICKS + 1)) && (lh_q <= LH_W'(MANUAL_HOLD_TICKS)))
		else $error("hold or timeout counter ran past its bound");

	a_roam_entry_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_q == MODE_MANUAL && mode_n == MODE_ROAM)
		|-> (lh_q >= LH_W'(MANUAL_HOLD_TICKS)))
		else $error("roam entered without a full left-stick hold");

	a_mode_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_word_q.run_mode == run_code(mode_q)))
		else $error("reported mode differs from stored mode");

endmodule

/* tb/ramc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramc_checker
// Watches both channels and the register port of the rover mode controller.
// It keeps its own copy of the registers and the controller state, predicts
// the drive word for every tick that is accepted, and compares each word
// that leaves the block with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ramc_checker import ramc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  ramc_in_t           in_word,
	input  logic               out_valid,
	input  logic               out_stall,
	input  ramc_out_t          out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               end_of_run,
	output int                 fail_count,
	output int                 pending,
	output int                 checked,
	output logic [3:0]         modes_seen
);

	logic [US_W-1:0]   left_limit;
	logic [US_W-1:0]   right_coarse;
	logic [US_W-1:0]   right_exact;
	logic [US_W-1:0]   stop_a;
	logic [US_W-1:0]   stop_b;
	logic [US_W-1:0]   forward_w;
	logic [US_W-1:0]   backward_w;
	logic [MM_W-1:0]   safe_range;

	logic [MODE_W-1:0] mode_now;
	int                right_hold;
	int                left_hold;
	int                search_cnt;
	int                lost_cnt;
	logic [MM_W-1:0]   target_mm;

	ramc_out_t         drive_queue[$];
	ramc_out_t         predicted;
	ramc_out_t         oldest;
	bit                end_checked;

	initial begin
		fail_count  = 0;
		pending     = 0;
		checked     = 0;
		modes_seen  = '0;
		end_checked = 1'b0;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (fail_count < 100)
			$display("mismatch: %s after %0d good words: got %0d, expected %0d",
				what, checked, got, want);
		fail_count++;
	endtask

	function automatic logic [MM_W-1:0] target_for(input logic [MM_W-1:0] rng);
		int t;
		t = int'(rng) - 25;
		if (t < int'(safe_range))
			t = int'(safe_range);
		return MM_W'(t);
	endfunction

	task automatic step_controller(input ramc_in_t w, output ramc_out_t r);
		int unsigned     prod;
		logic [MM_W-1:0] rng;
		bit              seen;
		logic [US_W-1:0] da;
		logic [US_W-1:0] db;
		rng = '0;
		if (w.echo_width_us <= ECHO_LIMIT_US) begin
			prod = w.echo_width_us * 17 / 100;
			rng = (prod > 1023) ? MM_W'(1023) : MM_W'(prod);
		end
		seen = rng > 5;

		// The right stick check runs ahead of the mode logic.
		if (w.pwm_a_in_us >= right_coarse) begin
			left_hold = 0;
			if (right_hold == RETURN_TICKS)
				mode_now = RUN_MANUAL;
			else
				right_hold++;
		end else begin
			right_hold = 0;
		end

		da = stop_a;
		db = stop_b;
		case (mode_now)
			RUN_TRACK: begin
				if (seen) begin
					if (int'(rng) > int'(target_mm) + 10)
						db = forward_w;
					else if (int'(rng) < int'(target_mm) - 10)
						db = backward_w;
				end else if (lost_cnt > LOST_TICKS) begin
					mode_now = RUN_SEARCH;
					lost_cnt = 0;
					search_cnt = 0;
					da = right_exact;
				end else begin
					lost_cnt++;
				end
			end
			RUN_SEARCH: begin
				if (seen) begin
					mode_now = RUN_TRACK;
					target_mm = target_for(rng);
				end else if (search_cnt >= SEARCH_TICKS) begin
					mode_now = RUN_ROAM;
					da = right_coarse;
				end else begin
					search_cnt++;
					da = right_exact;
				end
			end
			RUN_ROAM: begin
				if (w.infrared_seen) begin
					if (seen) begin
						mode_now = RUN_TRACK;
						target_mm = target_for(rng);
					end else begin
						mode_now = RUN_SEARCH;
						search_cnt = 0;
						da = right_exact;
					end
				end else begin
					da = right_coarse;
				end
			end
			default: begin
				da = w.pwm_a_in_us;
				db = w.pwm_b_in_us;
				if (w.pwm_a_in_us <= left_limit) begin
					if (left_hold >= MANUAL_HOLD_TICKS) begin
						mode_now = RUN_ROAM;
						left_hold = 0;
						da = right_coarse;
						db = stop_b;
					end else begin
						left_hold++;
					end
				end else begin
					left_hold = 0;
				end
			end
		endcase

		r.drive_a_us = da;
		r.drive_b_us = db;
		r.run_mode   = mode_now;
		r.range_mm   = rng;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_limit   = LEFT_LIMIT_RST;
			right_coarse = RIGHT_COARSE_RST;
			right_exact  = RIGHT_EXACT_RST;
			stop_a       = STOP_A_RST;
			stop_b       = STOP_B_RST;
			forward_w    = FORWARD_RST;
			backward_w   = BACKWARD_RST;
			safe_range   = SAFE_RANGE_RST;
			mode_now     = RUN_MANUAL;
			right_hold   = 0;
			left_hold    = 0;
			search_cnt   = 0;
			lost_cnt     = 0;
			target_mm    = '0;
			drive_queue.delete();
			pending      = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_LEFT_LIMIT:   left_limit   = pwdata[US_W-1:0];
					REG_RIGHT_COARSE: right_coarse = pwdata[US_W-1:0];
					REG_RIGHT_EXACT:  right_exact  = pwdata[US_W-1:0];
					REG_STOP_A:       stop_a       = pwdata[US_W-1:0];
					REG_STOP_B:       stop_b       = pwdata[US_W-1:0];
					REG_FORWARD:      forward_w    = pwdata[US_W-1:0];
					REG_BACKWARD:     backward_w   = pwdata[US_W-1:0];
					default:          safe_range   = pwdata[MM_W-1:0];
				endcase
			end

			if (in_valid && !in_stall) begin
				step_controller(in_word, predicted);
				drive_queue.push_back(predicted);
			end

			if (out_valid && !out_stall) begin
				if (drive_queue.size() == 0) begin
					flag_mismatch("word with no tick behind it", out_word.run_mode, -1);
				end else begin
					oldest = drive_queue.pop_front();
					if (out_word.drive_a_us !== oldest.drive_a_us)
						flag_mismatch("drive_a_us", out_word.drive_a_us, oldest.drive_a_us);
					if (out_word.drive_b_us !== oldest.drive_b_us)
						flag_mismatch("drive_b_us", out_word.drive_b_us, oldest.drive_b_us);
					if (out_word.run_mode !== oldest.run_mode)
						flag_mismatch("run_mode", out_word.run_mode, oldest.run_mode);
					if (out_word.range_mm !== oldest.range_mm)
						flag_mismatch("range_mm", out_word.range_mm, oldest.range_mm);
					modes_seen[oldest.run_mode] = 1'b1;
					checked++;
				end
			end

			if (end_of_run && !end_checked) begin
				end_checked = 1'b1;
				if (drive_queue.size() != 0)
					flag_mismatch("words never delivered", 0, drive_queue.size());
			end
			pending = drive_queue.size();
		end
	end

endmodule

/* tb/tb_rover_autonomy_mode_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rover_autonomy_mode_controller_core
// Drives control ticks into the rover mode controller under five register
// settings, with random gaps and output stalls, and lets ramc_checker judge
// every word. Ticks come mostly as stick holds, sightings and losses that
// walk the controller through all four modes, mixed with random noise.
// ----------------------------------------------------------------------------
module tb_rover_autonomy_mode_controller_core;
	import ramc_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 8;

	typedef enum {A_LEFT, A_RIGHT, A_MID, A_ANY} a_pick_t;
	typedef enum {E_FAR, E_NEAR, E_ANY} echo_pick_t;
	typedef enum {IR_OFF, IR_ON, IR_RAND} ir_pick_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	ramc_in_t           in_word;
	logic               out_valid;
	logic               out_stall;
	ramc_out_t          out_word;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               end_of_run;

	int                 fail_count;
	int                 pending;
	int                 checked;
	logic [3:0]         modes_seen;

	bit                 in_idle_en;
	bit                 out_idle_en;
	bit                 hold_req;
	int                 hold_offs;
	int                 ticks_sent;
	int                 cycle_count;
	int unsigned        cfg_now[8];
	int unsigned        next_cfg[8];

	rover_autonomy_mode_controller_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	ramc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.end_of_run (end_of_run),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.modes_seen (modes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin
		int hold_len;
		out_stall = 1'b0;
		hold_offs = 0;
		forever begin
			@(negedge clk);
			hold_len = 0;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_offs++;
				hold_len = HOLD_OFF_CYCLES;
			end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
				hold_len = $urandom_range(1, 15);
			end
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	function automatic ramc_in_t tick(input int unsigned a, input int unsigned b,
			input int unsigned echo, input bit ir);
		ramc_in_t w;
		w.pwm_a_in_us   = US_W'(a);
		w.pwm_b_in_us   = US_W'(b);
		w.echo_width_us = ECHO_W'(echo);
		w.infrared_seen = ir;
		return w;
	endfunction

	function automatic int unsigned pick_a(input a_pick_t k);
		int unsigned lo;
		int unsigned hi;
		lo = cfg_now[REG_LEFT_LIMIT] + 1;
		hi = (cfg_now[REG_RIGHT_COARSE] > 0) ? cfg_now[REG_RIGHT_COARSE] - 1 : 0;
		case (k)
			A_LEFT:  return $urandom_range(0, cfg_now[REG_LEFT_LIMIT]);
			A_RIGHT: return $urandom_range(cfg_now[REG_RIGHT_COARSE], 15000);
			A_MID:   return (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 15000);
			default: return $urandom_range(0, 15000);
		endcase
	endfunction

	// Far echoes give no usable range: either too short or past the limit.
	function automatic int unsigned pick_echo(input echo_pick_t k);
		case (k)
			E_FAR:   return $urandom_range(0, 1) ? $urandom_range(0, 35)
			                                     : $urandom_range(4001, 65535);
			E_NEAR:  return $urandom_range(36, 4000);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic bit pick_ir(input ir_pick_t k);
		case (k)
			IR_OFF:  return 1'b0;
			IR_ON:   return 1'b1;
			default: return $urandom_range(0, 1);
		endcase
	endfunction

	// Called on a falling edge; returns on the falling edge after acceptance.
	task automatic send_tick(input ramc_in_t w);
		if (in_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		ticks_sent++;
	endtask

	task automatic send_run(input int n, input a_pick_t ak, input echo_pick_t ek,
			input ir_pick_t ik);
		repeat (n)
			send_tick(tick(pick_a(ak), $urandom_range(0, 15000), pick_echo(ek), pick_ir(ik)));
	endtask

	// Range jitters around a base so that the target band is crossed both
	// ways, with the odd tick where the echo is lost.
	task automatic track_run(input int n);
		int base;
		int e;
		base = $urandom_range(36, 4000);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0) begin
				e = pick_echo(E_FAR);
			end else begin
				e = base + int'($urandom_range(0, 240)) - 120;
				if (e < 36)
					e = 36;
				if (e > 4000)
					e = 4000;
			end
			send_tick(tick(pick_a(A_MID), $urandom_range(0, 15000), e, pick_ir(IR_RAND)));
		end
	endtask

	task automatic run_episode();
		int len;
		case ($urandom_range(0, 9))
			0, 1: begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
				                                  : $urandom_range(101, 106);
				send_run(len, A_LEFT, E_ANY, IR_RAND);
			end
			2: begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
				                                  : $urandom_range(51, 55);
				send_run(len, A_RIGHT, E_ANY, IR_RAND);
			end
			3: begin
				send_run(1, A_MID, E_FAR, IR_ON);
				send_run($urandom_range(3, 40), A_MID, E_FAR, IR_RAND);
			end
			4: begin
				send_run(1, A_MID, E_NEAR, IR_ON);
				track_run($urandom_range(10, 40));
			end
			5: track_run($urandom_range(10, 40));
			6: send_run($urandom_range(25, 40), A_MID, E_FAR, IR_RAND);
			7: send_run($urandom_range(3, 12), A_ANY, E_ANY, IR_RAND);
			default: send_run($urandom_range(3, 10), A_MID, E_ANY, IR_RAND);
		endcase
	endtask

	task automatic random_phase(input int n);
		int stop_at;
		stop_at = ticks_sent + n;
		while (ticks_sent < stop_at)
			run_episode();
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		cfg_now[idx] = val;
	endtask

	task automatic apply_config();
		for (int i = 0; i < 8; i++)
			write_reg(reg_idx_t'(i), next_cfg[i]);
	endtask

	// Let every predicted word drain before the registers change.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_word     = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		end_of_run  = 1'b0;
		in_idle_en  = 1'b1;
		out_idle_en = 1'b1;
		hold_req    = 1'b0;
		ticks_sent  = 0;
		next_cfg = '{LEFT_LIMIT_RST, RIGHT_COARSE_RST, RIGHT_EXACT_RST, STOP_A_RST,
			STOP_B_RST, FORWARD_RST, BACKWARD_RST, SAFE_RANGE_RST};
		cfg_now = next_cfg;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Field extremes, echo limit edges, the seen threshold and stick edges.
		send_tick(tick(0, 0, 0, 0));
		send_tick(tick(15000, 15000, 65535, 1));
		send_tick(tick(1500, 13500, 4000, 0));
		send_tick(tick(1500, 13500, 4001, 1));
		send_tick(tick(1500, 0, 29, 0));
		send_tick(tick(1500, 15000, 35, 1));
		send_tick(tick(1500, 13500, 36, 0));
		send_tick(tick(1200, 13500, 100, 0));
		send_tick(tick(1201, 13500, 100, 0));
		send_tick(tick(1799, 13500, 3999, 1));
		send_tick(tick(1800, 13500, 3999, 0));
		send_tick(tick(8191, 8191, 32767, 0));
		send_tick(tick(10922, 5461, 43690, 1));
		send_tick(tick(5461, 10922, 21845, 0));
		send_tick(tick(1500, 13500, 60000, 1));

		// A full tour: back to manual, roam, search until it times out, track,
		// lose the target, then the right stick back to manual.
		send_run(RETURN_TICKS + 1, A_RIGHT, E_FAR, IR_OFF);
		send_run(MANUAL_HOLD_TICKS + 1, A_LEFT, E_FAR, IR_OFF);
		send_run(1, A_MID, E_FAR, IR_ON);
		send_run(SEARCH_TICKS + 5, A_MID, E_FAR, IR_RAND);
		send_run(1, A_MID, E_NEAR, IR_ON);
		track_run(20);
		send_run(LOST_TICKS + 5, A_MID, E_FAR, IR_OFF);
		send_run(RETURN_TICKS + 1, A_RIGHT, E_ANY, IR_RAND);
		random_phase(20);
		settle();

		// Random thresholds; the output side holds off long enough to back up.
		next_cfg[REG_LEFT_LIMIT]   = $urandom_range(0, 3000);
		next_cfg[REG_RIGHT_COARSE] = $urandom_range(next_cfg[REG_LEFT_LIMIT] + 1, 15000);
		next_cfg[REG_RIGHT_EXACT]  = $urandom_range(0, 15000);
		next_cfg[REG_STOP_A]       = $urandom_range(0, 15000);
		next_cfg[REG_STOP_B]       = $urandom_range(0, 15000);
		next_cfg[REG_FORWARD]      = $urandom_range(0, 15000);
		next_cfg[REG_BACKWARD]     = $urandom_range(0, 15000);
		next_cfg[REG_SAFE_RANGE]   = $urandom_range(0, 1023);
		apply_config();
		hold_req = 1'b1;
		random_phase(40);
		settle();

		// Top extremes: left and right stick overlap at full scale.
		next_cfg = '{15000, 15000, 15000, 15000, 15000, 0, 15000, 1023};
		apply_config();
		random_phase(20);
		settle();

		// Bottom extremes.
		next_cfg = '{0, 15000, 0, 0, 0, 15000, 0, 0};
		apply_config();
		random_phase(15);
		settle();

		// Back to defaults, with both sides running flat out.
		next_cfg = '{LEFT_LIMIT_RST, RIGHT_COARSE_RST, RIGHT_EXACT_RST, STOP_A_RST,
			STOP_B_RST, FORWARD_RST, BACKWARD_RST, SAFE_RANGE_RST};
		apply_config();
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		random_phase(25);
		settle();

		end_of_run <= 1'b1;
		@(negedge clk);
		@(negedge clk);

		$display("Drove %0d ticks under five register settings, %0d long output hold-off(s).",
			ticks_sent, hold_offs);
		$display("Compared %0d words; run modes reached (track search roam manual): %b.",
			checked, modes_seen);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
